FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/chhic_pkg.sv
// Constants, arctangent table and state type for the compass heading block.
package chhic_pkg;

  localparam int LIMIT_W      = 13;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd500;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = 4;
  localparam int PRESCALE     = 16;
  localparam int ANGLE_W      = 32;
  localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROT,
    BK_MUL,
    BK_FIN,
    BK_OUT
  } back_state_t;

  // atan(2^-i) as a binary angle, full turn = 2^32
  function automatic logic [ANGLE_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [ANGLE_W-1:0] v;
    case (i)
      4'd0:    v = 32'h2000_0000;
      4'd1:    v = 32'h12E4_051E;
      4'd2:    v = 32'h09FB_385B;
      4'd3:    v = 32'h0511_11D4;
      4'd4:    v = 32'h028B_0D43;
      4'd5:    v = 32'h0145_D7E1;
      4'd6:    v = 32'h00A2_F61E;
      4'd7:    v = 32'h0051_7C55;
      4'd8:    v = 32'h0028_BE53;
      4'd9:    v = 32'h0014_5F2F;
      4'd10:   v = 32'h000A_2F98;
      4'd11:   v = 32'h0005_17CC;
      4'd12:   v = 32'h0002_8BE6;
      4'd13:   v = 32'h0001_45F3;
      4'd14:   v = 32'h0000_A2FA;
      4'd15:   v = 32'h0000_517D;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/chhic_front.sv
// Front end: takes samples, filters calibration data, keeps extremes, centers read samples.
module chhic_front #(
  parameter int SAMPLE_WIDTH = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic                                cmd,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_x,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_y,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_z,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [chhic_pkg::LIMIT_W-1:0]       cfg_data,
  output logic                                q_push,
  input  logic                                q_ready,
  output logic                                q_cmd,
  output logic                                q_acc,
  output logic signed [SAMPLE_WIDTH+1:0]      q_dx,
  output logic signed [SAMPLE_WIDTH+1:0]      q_dy
);
  import chhic_pkg::*;

  localparam int DW = SAMPLE_WIDTH + 2;
  localparam int CW = ((SAMPLE_WIDTH + 1 > LIMIT_W) ? SAMPLE_WIDTH + 1 : LIMIT_W) + 1;

  logic [LIMIT_W-1:0]            reject_limit;
  logic signed [SAMPLE_WIDTH-1:0] x_high, x_low, y_high, y_low;
  logic signed [CW-1:0]          ex, ey, ez, ax, ay, az, lim;
  logic                          pass;

  assign cfg_ready = 1'b1;
  assign s_tready  = q_ready;
  assign q_push    = s_tvalid && q_ready;

  always_comb begin
    ex   = CW'(sample_x);
    ey   = CW'(sample_y);
    ez   = CW'(sample_z);
    ax   = ex[CW-1] ? -ex : ex;
    ay   = ey[CW-1] ? -ey : ey;
    az   = ez[CW-1] ? -ez : ez;
    lim  = CW'({1'b0, reject_limit});
    pass = (ax < lim) && (ay < lim) && (az < lim);
  end

  assign q_cmd = cmd;
  assign q_acc = !cmd && pass;
  // half-count offsets: 2*s - (high + low)
  assign q_dx  = (DW'(sample_x) <<< 1) - (DW'(x_high) + DW'(x_low));
  assign q_dy  = (DW'(sample_y) <<< 1) - (DW'(y_high) + DW'(y_low));

  always_ff @(posedge clk) begin
    if (rst) begin
      reject_limit <= LIMIT_RESET;
      x_high       <= '0;
      x_low        <= '0;
      y_high       <= '0;
      y_low        <= '0;
    end else begin
      if (cfg_valid) begin
        reject_limit <= cfg_data;
      end
      if (q_push && q_acc) begin
        if (sample_x > x_high) x_high <= sample_x;
        if (sample_x < x_low)  x_low  <= sample_x;
        if (sample_y > y_high) y_high <= sample_y;
        if (sample_y < y_low)  y_low  <= sample_y;
      end
    end
  end

endmodule

FILE: sv/chhic_queue.sv
// Small register queue between the front end and the heading engine.
module chhic_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             ready,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);
  import chhic_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CNTW-1:0]  count;

  assign ready = (count != CNTW'(DEPTH));
  assign valid = (count != '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

`include "assert_macros.svh"
  `ASSERT_ALWAYS(a_q_count_bound, count <= CNTW'(DEPTH), "queue count above depth")
  `ASSERT_IMPL(a_q_no_underflow, pop, count != '0, "pop from empty queue")
  `ASSERT_NEXT(a_q_fill, push && !pop, count == $past(count) + 1'b1, "queue count lost a push")

endmodule

FILE: sv/chhic_back.sv
// Heading engine: iterative CORDIC vectoring, scaling to degrees, output register.
module chhic_back #(
  parameter int SAMPLE_WIDTH      = 12,
  parameter int HEADING_FRAC_BITS = 6
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      q_valid,
  output logic                                      q_pop,
  input  logic                                      q_cmd,
  input  logic                                      q_acc,
  input  logic signed [SAMPLE_WIDTH+1:0]            q_dx,
  input  logic signed [SAMPLE_WIDTH+1:0]            q_dy,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [$clog2(360*(2**HEADING_FRAC_BITS))-1:0] heading,
  output logic                                      accepted
);
  import chhic_pkg::*;

  localparam int XW     = SAMPLE_WIDTH + 20;
  localparam int FULL_I = 360 * (2 ** HEADING_FRAC_BITS);
  localparam int HW     = $clog2(FULL_I);
  localparam int PW     = ANGLE_W + HW;

  back_state_t          state, state_next;
  logic signed [XW-1:0] x, y, x0, y0, xs, ys, x_rot, y_rot;
  logic [ANGLE_W-1:0]   angle, angle_rot;
  logic [STEP_W-1:0]    step;
  logic [PW-1:0]        prod, rounded;
  logic [HW-1:0]        h_raw;
  logic                 nonzero;

  assign q_pop    = (state == BK_IDLE) && q_valid;
  assign m_tvalid = (state == BK_OUT);
  assign nonzero  = (q_dx != '0) || (q_dy != '0);
  assign x0       = XW'(q_dx) <<< PRESCALE;
  assign y0       = XW'(q_dy) <<< PRESCALE;

  always_comb begin
    xs = x >>> step;
    ys = y >>> step;
    if (!y[XW-1]) begin
      x_rot     = x + ys;
      y_rot     = y - xs;
      angle_rot = angle + atan_lut(step);
    end else begin
      x_rot     = x - ys;
      y_rot     = y + xs;
      angle_rot = angle - atan_lut(step);
    end
  end

  // round to nearest step of the output scale
  assign rounded = prod + (PW'(1) << (ANGLE_W - 1));
  assign h_raw   = rounded[PW-1:ANGLE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (q_valid) state_next = (q_cmd && nonzero) ? BK_ROT : BK_OUT;
      BK_ROT:  if (step == STEP_W'(CORDIC_STEPS - 1)) state_next = BK_MUL;
      BK_MUL:  state_next = BK_FIN;
      BK_FIN:  state_next = BK_OUT;
      BK_OUT:  if (m_tready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          accepted <= q_acc;
          heading  <= '0;
          step     <= '0;
          // left half plane: rotate by a half turn first
          x        <= x0[XW-1] ? -x0 : x0;
          y        <= x0[XW-1] ? -y0 : y0;
          angle    <= x0[XW-1] ? HALF_TURN : '0;
        end
      end
      BK_ROT: begin
        x     <= x_rot;
        y     <= y_rot;
        angle <= angle_rot;
        step  <= step + 1'b1;
      end
      BK_MUL:  prod    <= PW'(angle) * PW'(FULL_I);
      BK_FIN:  heading <= (h_raw >= HW'(FULL_I)) ? '0 : h_raw;
      default: ;
    endcase
  end

`include "assert_macros.svh"
  `ASSERT_IMPL(a_bk_range, m_tvalid, heading < HW'(FULL_I), "heading out of range")
  `ASSERT_IMPL(a_bk_acc_zero, m_tvalid && accepted, heading == '0,
               "accepted calibration item with nonzero heading")
  `ASSERT_IMPL(a_bk_step, state == BK_ROT && $past(state) == BK_ROT,
               step == $past(step) + 1'b1, "CORDIC step counter skipped")

endmodule

FILE: sv/compass_heading_hard_iron_cal_top.sv
// Top level of the compass heading block with hard-iron calibration.
//
//  channel  | group               | contents
//  ---------+---------------------+-------------------------------------------
//  input    | s_tvalid/s_tready   | tdata: sample_x, sample_y, sample_z; tuser: cmd
//  output   | m_tvalid/m_tready   | tdata: heading; tuser: accepted
//  config   | cfg_valid/cfg_ready | cfg_data: reject_limit
//
// In the heading engine a read request with a nonzero offset goes through a load,
// 16 CORDIC iterations of the shared shift-add unit, one multiply, one rounding and
// one output step. A calibration request or a zero-offset read goes from the load
// straight to the output. The front end accepts one request per cycle while the
// two-entry queue has room. Reset clears extremes to zero and reject_limit to 500.
// The output holds its result until m_tready.
module compass_heading_hard_iron_cal_top #(
  parameter int SAMPLE_WIDTH      = 12,
  parameter int HEADING_FRAC_BITS = 6
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // sample_x, sample_y, sample_z, zero fill
  input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata,
  // cmd
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // heading, zero fill
  output logic [(($clog2(360*(2**HEADING_FRAC_BITS))+7)/8)*8-1:0] m_tdata,
  // accepted
  output logic                                 m_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [chhic_pkg::LIMIT_W-1:0]        cfg_data
);
  import chhic_pkg::*;

  localparam int DW     = SAMPLE_WIDTH + 2;
  localparam int QW     = 2 + 2 * DW;
  localparam int HW     = $clog2(360 * (2 ** HEADING_FRAC_BITS));
  localparam int OUT_TW = ((HW + 7) / 8) * 8;

  logic                 f_push, f_ready, f_cmd, f_acc;
  logic signed [DW-1:0] f_dx, f_dy;
  logic                 b_valid, b_pop;
  logic [QW-1:0]        b_data;
  logic [HW-1:0]        heading;

  chhic_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cmd       (s_tuser),
    .sample_x  (s_tdata[SAMPLE_WIDTH-1:0]),
    .sample_y  (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .sample_z  (s_tdata[3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH]),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_push    (f_push),
    .q_ready   (f_ready),
    .q_cmd     (f_cmd),
    .q_acc     (f_acc),
    .q_dx      (f_dx),
    .q_dy      (f_dy)
  );

  chhic_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata ({f_cmd, f_acc, f_dx, f_dy}),
    .ready (f_ready),
    .pop   (b_pop),
    .valid (b_valid),
    .rdata (b_data)
  );

  chhic_back #(
    .SAMPLE_WIDTH      (SAMPLE_WIDTH),
    .HEADING_FRAC_BITS (HEADING_FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (b_valid),
    .q_pop    (b_pop),
    .q_cmd    (b_data[QW-1]),
    .q_acc    (b_data[QW-2]),
    .q_dx     (b_data[2*DW-1:DW]),
    .q_dy     (b_data[DW-1:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .heading  (heading),
    .accepted (m_tuser)
  );

  assign m_tdata = OUT_TW'(heading);

endmodule
